// ===== hw/rtl/fsrks_pkg.sv =====
// Shared types and constants of the two-level force-sensor keypad scanner.
package fsrks_pkg;

    localparam int THR_BITS   = 10;   // width of one threshold field
    localparam int FIELD_CH   = 4;    // channels with their own fields and samples
    localparam int STAMP_BITS = 32;
    localparam int DEB_BITS   = 16;
    localparam int KEY_BITS   = 8;
    localparam int KEY_IDX_W  = 3;    // eight key bytes in the table
    localparam int THR_REG_W  = THR_BITS * FIELD_CH;
    localparam int TABLE_W    = KEY_BITS * (1 << KEY_IDX_W);
    localparam int CFG_IDX_W  = 2;

    localparam logic [THR_REG_W-1:0] LIGHT_RESET    = 40'd5373957125;
    localparam logic [THR_REG_W-1:0] HEAVY_RESET    = 40'd75235399750;
    localparam logic [DEB_BITS-1:0]  DEBOUNCE_RESET = 16'd50;

    // What a channel reports on one poll
    typedef enum logic [1:0] {
        REP_ZERO  = 2'd0,
        REP_LIGHT = 2'd1,
        REP_HEAVY = 2'd2,
        REP_NONE  = 2'd3
    } t_report;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIGHT    = 2'd0,
        CFG_HEAVY    = 2'd1,
        CFG_DEBOUNCE = 2'd2,
        CFG_KEYS     = 2'd3
    } t_cfg_idx;

    // Thresholds and hold time handed to every channel
    typedef struct packed {
        logic [THR_BITS-1:0] light;
        logic [THR_BITS-1:0] heavy;
        logic [DEB_BITS-1:0] debounce;
    } t_chan_cfg;

endpackage

// ===== hw/rtl/fsrks_chan.sv =====
// One channel: level classing, debounce state and its report for the current poll.
module fsrks_chan
    import fsrks_pkg::*;
#(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [STAMP_BITS-1:0]  i_now_ms,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  t_chan_cfg              i_cfg,
    input  logic                   i_update,
    output t_report                o_report
);

    localparam int CMP_W = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;

    logic [STAMP_BITS-1:0] r_stamp;
    logic [1:0]            r_raw_prev;
    logic [1:0]            r_stable;

    logic [CMP_W-1:0]      sample_x;
    logic [CMP_W-1:0]      light_x;
    logic [CMP_W-1:0]      heavy_x;
    logic [1:0]            level;
    logic [STAMP_BITS-1:0] n_stamp;
    logic [STAMP_BITS-1:0] elapsed;
    logic                  expired;
    logic                  take;

    assign sample_x = CMP_W'(i_sample);
    assign light_x  = CMP_W'(i_cfg.light);
    assign heavy_x  = CMP_W'(i_cfg.heavy);

    always_comb begin
        if (sample_x <= light_x) begin
            level = REP_ZERO;
        end else if (sample_x <= heavy_x) begin
            level = REP_LIGHT;
        end else begin
            level = REP_HEAVY;
        end
    end

    // A change of raw level restarts the hold timer; wrap is harmless mod 2^32
    assign n_stamp = (level != r_raw_prev) ? i_now_ms : r_stamp;
    assign elapsed = i_now_ms - n_stamp;
    assign expired = elapsed > STAMP_BITS'(i_cfg.debounce);
    assign take    = expired && (level != r_stable);

    always_comb begin
        if (take) begin
            o_report = t_report'(level);
        end else if (expired && r_stable == REP_ZERO) begin
            o_report = REP_ZERO;
        end else begin
            o_report = REP_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stamp    <= '0;
            r_raw_prev <= REP_ZERO;
            r_stable   <= REP_ZERO;
        end else if (i_update) begin
            r_stamp    <= n_stamp;
            r_raw_prev <= level;
            if (take) begin
                r_stable <= level;
            end
        end
    end

endmodule

// ===== hw/rtl/fsr_two_level_keypad_scanner.sv =====
// Top level of the two-level force-sensor keypad scanner.
//
// Each poll (now_ms and one force sample per channel) gives exactly one result:
// a key flag in tuser and the key byte in tdata (zero when no key). A poll is
// registered on entry, classed and debounced by one pass of per-channel logic,
// and the result lands in an output register, so a poll can be taken every
// cycle and its result is offered once it moves from the input register to the
// output; the only limit is the downstream tready. Channel state updates when
// a poll moves into the output register, so the next poll sees it straight
// away. Thresholds, hold time and key table are written over the configuration
// channel, which is always ready; write them only while no poll is in flight.
module fsr_two_level_keypad_scanner
    import fsrks_pkg::*;
#(
    parameter int CHANNELS    = 4,
    parameter int SAMPLE_BITS = 10,
    localparam int IN_BITS    = STAMP_BITS + FIELD_CH * SAMPLE_BITS,
    localparam int IN_W       = ((IN_BITS + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // poll in
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [IN_W-1:0]      i_s_axis_tdata,  // now_ms, sample_0..sample_3, zero pad
    // result out
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [KEY_BITS-1:0]  o_m_axis_tdata,  // key_char
    output logic                 o_m_axis_tuser,  // key_valid
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TABLE_W-1:0]   i_cfg_data
);

    logic [THR_REG_W-1:0] r_light;
    logic [THR_REG_W-1:0] r_heavy;
    logic [DEB_BITS-1:0]  r_debounce;
    logic [TABLE_W-1:0]   r_key_table;

    logic [IN_W-1:0]      r_in_data;
    logic                 r_in_valid;
    logic                 r_key_held;
    logic                 r_out_valid;
    logic                 r_out_key_valid;
    logic [KEY_BITS-1:0]  r_out_key_char;

    logic                 advance;
    logic                 commit;
    t_report              report  [CHANNELS];
    logic [CHANNELS-1:0]  hit;
    logic [CHANNELS-1:0]  upd;
    logic                 any_hit;
    logic [KEY_IDX_W-1:0] key_idx;
    logic                 n_key_valid;
    logic [KEY_BITS-1:0]  n_key_char;

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light     <= LIGHT_RESET;
            r_heavy     <= HEAVY_RESET;
            r_debounce  <= DEBOUNCE_RESET;
            r_key_table <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_LIGHT:    r_light     <= i_cfg_data[THR_REG_W-1:0];
                CFG_HEAVY:    r_heavy     <= i_cfg_data[THR_REG_W-1:0];
                CFG_DEBOUNCE: r_debounce  <= i_cfg_data[DEB_BITS-1:0];
                CFG_KEYS:     r_key_table <= i_cfg_data;
                default:      r_key_table <= r_key_table;
            endcase
        end
    end

    // ---------------- handshake ----------------
    assign advance         = !r_out_valid || i_m_axis_tready;
    assign commit          = r_in_valid && advance;
    assign o_s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_data <= i_s_axis_tdata;
        end
    end

    // ---------------- channels ----------------
    for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_chan
        localparam int FLD = ch % FIELD_CH;
        t_chan_cfg chan_cfg;

        assign chan_cfg.light    = r_light[FLD*THR_BITS +: THR_BITS];
        assign chan_cfg.heavy    = r_heavy[FLD*THR_BITS +: THR_BITS];
        assign chan_cfg.debounce = r_debounce;

        fsrks_chan #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_chan (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_now_ms (r_in_data[STAMP_BITS-1:0]),
            .i_sample (r_in_data[STAMP_BITS + FLD*SAMPLE_BITS +: SAMPLE_BITS]),
            .i_cfg    (chan_cfg),
            .i_update (commit && upd[ch]),
            .o_report (report[ch])
        );

        // held: anything but a settled zero stops the scan; idle: a new press
        assign hit[ch] = r_key_held ? (report[ch] != REP_ZERO)
                                    : (report[ch] == REP_LIGHT || report[ch] == REP_HEAVY);
    end

    // Scan in channel order: channels after the first hit keep their state
    always_comb begin
        any_hit = 1'b0;
        key_idx = '0;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            upd[ch] = !any_hit;
            if (!any_hit && hit[ch]) begin
                key_idx = KEY_IDX_W'((ch % FIELD_CH) * 2) |
                          KEY_IDX_W'(report[ch] == REP_HEAVY);
            end
            any_hit = any_hit | hit[ch];
        end
    end

    assign n_key_valid = !r_key_held && any_hit;
    assign n_key_char  = n_key_valid ? r_key_table[key_idx*KEY_BITS +: KEY_BITS] : '0;

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_key_held  <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (commit) begin
                r_key_held <= any_hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_key_valid <= n_key_valid;
            r_out_key_char  <= n_key_char;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_key_char;
    assign o_m_axis_tuser  = r_out_key_valid;

    // ---------------- assertions ----------------
    a_no_key_while_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && r_key_held) |=> !r_out_key_valid)
        else $error("key reported while a key was held");

    a_held_rises_with_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_key_held) |-> (r_out_valid && r_out_key_valid))
        else $error("held mode entered without a key result");

    a_char_zero_without_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> (o_m_axis_tdata == '0))
        else $error("key byte non-zero without a key");

    a_stalled_poll_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_data)))
        else $error("registered poll lost during stall");

endmodule
